// ===== src/bpip_pkg.sv =====
// ----------------------------------------------------------------------------
// Busy-phase interval profiler package
// Shared widths, register reset values, codes and types.
// ----------------------------------------------------------------------------
package bpip_pkg;

	localparam int STATUS_W = 32;
	localparam int TIME_W   = 64;
	localparam int MASK_W   = 32;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_TRK  = 4;

	// Tracker slots.
	localparam int TRK_SAVE    = 0;
	localparam int TRK_LOAD    = 1;
	localparam int TRK_SAVE_MM = 2;
	localparam int TRK_LOAD_MM = 3;

	localparam logic [MASK_W-1:0] RUN_MASK_RST     = 32'h0000_0010;
	localparam logic [MASK_W-1:0] SAVE_MASK_RST    = 32'h0000_0080;
	localparam logic [MASK_W-1:0] LOAD_MASK_RST    = 32'h0000_0040;
	localparam logic [MASK_W-1:0] SAVE_MM_MASK_RST = 32'h0000_0082;
	localparam logic [MASK_W-1:0] LOAD_MM_MASK_RST = 32'h0000_0042;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RUN_MASK     = 3'd0,
		CFG_SAVE_MASK    = 3'd1,
		CFG_LOAD_MASK    = 3'd2,
		CFG_SAVE_MM_MASK = 3'd3,
		CFG_LOAD_MM_MASK = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_INVALID = 3'b001,
		PH_IDLE    = 3'b010,
		PH_RUN     = 3'b100
	} phase_t;

	typedef struct packed {
		logic [MASK_W-1:0]              run;
		logic [NUM_TRK-1:0][MASK_W-1:0] trk;
	} masks_t;

	typedef struct packed {
		logic step;   // running sample, update the tracker
		logic clear;  // run ends, drop start and duration
	} trk_ctrl_t;

endpackage

// ===== src/bpip_sample_if.sv =====
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one timestamped status sample.
// ----------------------------------------------------------------------------
interface bpip_sample_if import bpip_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status_word;
	logic [TIME_W-1:0]   timestamp;

	modport source (output valid, output status_word, output timestamp, input ready);
	modport sink (input valid, input status_word, input timestamp, output ready);
endinterface

// ===== src/bpip_report_if.sv =====
// ----------------------------------------------------------------------------
// Report channel
// Valid/ready channel carrying one run report.
// ----------------------------------------------------------------------------
interface bpip_report_if import bpip_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] report_time;
	logic [TIME_W-1:0] run_total;
	logic [TIME_W-1:0] save_time;
	logic [TIME_W-1:0] save_mm_time;
	logic [TIME_W-1:0] load_time;
	logic [TIME_W-1:0] load_mm_time;

	modport source (output valid, output report_time, output run_total, output save_time,
		output save_mm_time, output load_time, output load_mm_time, input ready);
	modport sink (input valid, input report_time, input run_total, input save_time,
		input save_mm_time, input load_time, input load_mm_time, output ready);
endinterface

// ===== src/bpip_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface bpip_cfg_if import bpip_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [MASK_W-1:0]    wr_data;

	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== src/bpip_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the run mask and the four tracker masks; writes to unused indexes
// are dropped.
// ----------------------------------------------------------------------------
module bpip_cfg_regs import bpip_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	bpip_cfg_if.sink   cfg,
	output masks_t     masks
);

	masks_t masks_q;

	assign cfg.ready = 1'b1;
	assign masks     = masks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			masks_q.run              <= RUN_MASK_RST;
			masks_q.trk[TRK_SAVE]    <= SAVE_MASK_RST;
			masks_q.trk[TRK_LOAD]    <= LOAD_MASK_RST;
			masks_q.trk[TRK_SAVE_MM] <= SAVE_MM_MASK_RST;
			masks_q.trk[TRK_LOAD_MM] <= LOAD_MM_MASK_RST;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				CFG_RUN_MASK:     masks_q.run              <= cfg.wr_data;
				CFG_SAVE_MASK:    masks_q.trk[TRK_SAVE]    <= cfg.wr_data;
				CFG_LOAD_MASK:    masks_q.trk[TRK_LOAD]    <= cfg.wr_data;
				CFG_SAVE_MM_MASK: masks_q.trk[TRK_SAVE_MM] <= cfg.wr_data;
				CFG_LOAD_MM_MASK: masks_q.trk[TRK_LOAD_MM] <= cfg.wr_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== src/bpip_tracker.sv =====
// ----------------------------------------------------------------------------
// Phase tracker
// Latches a start time when all mask bits are set and records the elapsed
// time when they all clear. A start of zero marks the tracker inactive.
// ----------------------------------------------------------------------------
module bpip_tracker import bpip_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  trk_ctrl_t           ctrl,
	input  logic [MASK_W-1:0]   mask,
	input  logic [STATUS_W-1:0] status,
	input  logic [TIME_W-1:0]   ts,
	output logic [TIME_W-1:0]   dur_now
);

	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] dur_q;
	logic [MASK_W-1:0] hits;
	logic              hit_all;
	logic              hit_none;
	logic              active;
	logic              finish;
	logic [TIME_W-1:0] elapsed;

	always_comb begin
		hits     = status & mask;
		hit_all  = (hits == mask);
		hit_none = (hits == '0);
		active   = (start_q != '0);
		elapsed  = ts - start_q;
		finish   = ctrl.step && active && hit_none;
		// The report sees the duration as updated by the same sample.
		dur_now  = finish ? elapsed : dur_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			dur_q   <= '0;
		end else if (ctrl.clear) begin
			start_q <= '0;
			dur_q   <= '0;
		end else if (ctrl.step) begin
			if (!active && hit_all) begin
				start_q <= ts;
			end else if (finish) begin
				dur_q   <= elapsed;
				start_q <= '0;
			end
		end
	end

endmodule

// ===== src/busy_phase_interval_profiler.sv =====
// ----------------------------------------------------------------------------
// Busy-phase interval profiler
// Takes timestamped status samples on the sample channel and emits one report
// per completed run on the report channel. Mask registers are written on the
// cfg channel, which is always ready; write them only while the block is idle.
// A sample transaction is captured into an input register and processed
// once the output register has room, when the phase and tracker state are
// updated and any report is loaded into the output register. A report thus
// passes the input and output registers after the sample that ends the run.
// One sample is taken every cycle while the receiver does not stall, as the
// phase and tracker state update for each sample. When the receiver stalls,
// the report holds in the output register, the sample in the input register
// waits, and sample ready drops only once both are occupied.
// After reset the block is in the invalid phase with all trackers cleared and
// the masks at their default values; it moves to idle on an all-zero sample.
// ----------------------------------------------------------------------------
module busy_phase_interval_profiler import bpip_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	bpip_sample_if.sink  sample,
	bpip_report_if.source report,
	bpip_cfg_if.sink     cfg
);

	masks_t                             masks;
	logic                               s1_valid_q;
	logic [STATUS_W-1:0]                status_s1;
	logic [TIME_W-1:0]                  ts_s1;
	logic                               out_valid_q;
	logic                               fire;
	logic                               run_hit;
	logic                               emit;
	phase_t                             phase_q;
	phase_t                             phase_d;
	logic [TIME_W-1:0]                  run_start_q;
	logic [TIME_W-1:0]                  run_start_d;
	trk_ctrl_t                          trk_ctrl;
	logic [NUM_TRK-1:0][TIME_W-1:0]     dur_now;
	logic [TIME_W-1:0]                  report_time_q;
	logic [TIME_W-1:0]                  run_total_q;
	logic [TIME_W-1:0]                  save_time_q;
	logic [TIME_W-1:0]                  save_mm_time_q;
	logic [TIME_W-1:0]                  load_time_q;
	logic [TIME_W-1:0]                  load_mm_time_q;

	bpip_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.masks  (masks)
	);

	// The held sample is processed once the output register has room.
	assign fire         = s1_valid_q && (!out_valid_q || report.ready);
	assign sample.ready = !s1_valid_q || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (sample.valid && sample.ready) begin
			s1_valid_q <= 1'b1;
		end else if (fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			status_s1 <= sample.status_word;
			ts_s1     <= sample.timestamp;
		end
	end

	assign run_hit = ((status_s1 & masks.run) != '0);

	always_comb begin
		phase_d        = phase_q;
		run_start_d    = run_start_q;
		trk_ctrl.step  = 1'b0;
		trk_ctrl.clear = 1'b0;
		emit           = 1'b0;
		if (fire) begin
			unique case (phase_q)
				PH_IDLE: begin
					// A run start is handled again as a running sample.
					if (run_hit) begin
						phase_d       = PH_RUN;
						run_start_d   = ts_s1;
						trk_ctrl.step = 1'b1;
					end
				end
				PH_RUN: begin
					trk_ctrl.step = 1'b1;
					if (!run_hit) begin
						emit           = 1'b1;
						trk_ctrl.clear = 1'b1;
						phase_d        = PH_IDLE;
						run_start_d    = '0;
					end
				end
				default: begin
					if (status_s1 == '0) begin
						phase_d = PH_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_INVALID;
			run_start_q <= '0;
		end else begin
			phase_q     <= phase_d;
			run_start_q <= run_start_d;
		end
	end

	for (genvar k = 0; k < NUM_TRK; k++) begin : g_trk
		bpip_tracker u_tracker (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (trk_ctrl),
			.mask    (masks.trk[k]),
			.status  (status_s1),
			.ts      (ts_s1),
			.dur_now (dur_now[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			report_time_q  <= ts_s1;
			run_total_q    <= ts_s1 - run_start_q;
			save_time_q    <= dur_now[TRK_SAVE];
			save_mm_time_q <= dur_now[TRK_SAVE_MM];
			load_time_q    <= dur_now[TRK_LOAD];
			load_mm_time_q <= dur_now[TRK_LOAD_MM];
		end
	end

	assign report.valid        = out_valid_q;
	assign report.report_time  = report_time_q;
	assign report.run_total    = run_total_q;
	assign report.save_time    = save_time_q;
	assign report.save_mm_time = save_mm_time_q;
	assign report.load_time    = load_time_q;
	assign report.load_mm_time = load_mm_time_q;

endmodule
